@@ hw/rtl/utd_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 terminal input decoder package
// Beat types, result kind codes and byte constants shared by the decoder
// and the code that connects to its channels.
// ----------------------------------------------------------------------------
package utd_pkg;

  // Input beat: one terminal byte plus end-of-chunk flag
  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_end;
  } in_beat_t;

  // Output beat: one decoded result
  typedef struct packed {
    logic [20:0] code_point;
    logic [1:0]  code_kind;
    logic        run_last;
  } out_beat_t;

  // One queued result, before the last-of-run flag is attached
  typedef struct packed {
    logic [20:0] cp;
    logic [1:0]  kind;
  } res_t;

  localparam int unsigned MaxResults = 4;

  // code_kind values
  localparam logic [1:0] KindAscii  = 2'd0;
  localparam logic [1:0] KindUtf8   = 2'd1;
  localparam logic [1:0] KindLatin1 = 2'd2;
  localparam logic [1:0] KindCtrl   = 2'd3;

  localparam logic [7:0] ByteEsc     = 8'h1b;
  localparam logic [7:0] ByteBracket = 8'h5b;  // '['
  localparam logic [7:0] ByteLowA    = 8'h61;  // 'a'
  localparam logic [7:0] ByteLowZ    = 8'h7a;  // 'z'

  // Sequence length implied by a lead byte; 0 for anything that is not a lead
  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] n;
    n = 3'd0;
    if ((lead & 8'he0) == 8'hc0) begin
      n = 3'd2;
    end else if ((lead & 8'hf0) == 8'he0) begin
      n = 3'd3;
    end else if ((lead & 8'hf8) == 8'hf0) begin
      n = 3'd4;
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/utd_stream_if.sv @@
// ----------------------------------------------------------------------------
// Decoder stream channel
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface utd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/utf8_terminal_input_decoder.sv @@
// ----------------------------------------------------------------------------
// UTF-8 terminal input decoder
// Turns terminal bytes into codepoints, folding ESC '[' control sequences.
// ----------------------------------------------------------------------------
// Takes one terminal byte per beat on in_i (with a chunk_end flag) and gives
// zero to four result beats on out_o. ASCII passes through, complete 2/3/4
// byte UTF-8 sequences come out as one codepoint (no overlong or range check),
// broken or cut-off sequences and stray high bytes come out byte by byte as
// Latin-1, and an ESC '[' control sequence is dropped up to its first
// lowercase letter (or the chunk end) and reported as codepoint 0. A byte is
// decoded in the cycle it is accepted and its results go into a four-entry
// result register that drains one beat per cycle while out_o is ready. The
// next byte is taken when the register is empty or its last beat leaves,
// so a byte with more results holds the input while the single output port
// drains them. run_last marks the final result of each input byte.
// ----------------------------------------------------------------------------
module utf8_terminal_input_decoder (
  input logic            clk_i,
  input logic            rst_ni,
  utd_stream_if.sink     in_i,
  utd_stream_if.source   out_o
);
  import utd_pkg::*;

  typedef enum logic [1:0] {
    ModeIdle,
    ModeUtf,
    ModeEsc,
    ModeCsi
  } mode_e;

  // Decoder state
  mode_e      mode_q, mode_d;
  logic [1:0] held_cnt_q, held_cnt_d;
  logic [7:0] held_q [3];
  logic       held_wr;
  logic [1:0] held_wr_idx;

  // Result register: queued results, remaining count and read pointer
  res_t       bnd_q [MaxResults];
  res_t       bnd_d [MaxResults];
  logic [2:0] rem_q, bnd_cnt;
  logic [1:0] idx_q;

  logic       in_acc, out_acc;
  logic [7:0] b;
  logic       chunk_end;

  assign b         = in_i.payload.in_byte;
  assign chunk_end = in_i.payload.chunk_end;

  // Take a new byte when the result register is empty or its last beat leaves now
  assign in_i.ready = (rem_q == 3'd0) || ((rem_q == 3'd1) && out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;

  assign out_o.valid              = (rem_q != 3'd0);
  assign out_o.payload.code_point = bnd_q[idx_q].cp;
  assign out_o.payload.code_kind  = bnd_q[idx_q].kind;
  assign out_o.payload.run_last   = (rem_q == 3'd1);

  // ---- Decode of a byte as seen from idle ----
  logic       fi_v;
  res_t       fi_res;
  mode_e      fi_mode;
  logic       fi_hold;  // byte starts a multibyte sequence

  always_comb begin
    fi_v    = 1'b0;
    fi_res  = '{cp: {13'd0, b}, kind: KindAscii};
    fi_mode = ModeIdle;
    fi_hold = 1'b0;
    if (b == ByteEsc) begin
      if (chunk_end) begin
        fi_v = 1'b1;
      end else begin
        fi_mode = ModeEsc;
      end
    end else if (!b[7]) begin
      fi_v = 1'b1;
    end else if ((seq_len(b) == 3'd0) || chunk_end) begin
      fi_v        = 1'b1;
      fi_res.kind = KindLatin1;
    end else begin
      fi_hold = 1'b1;
      fi_mode = ModeUtf;
    end
  end

  // ---- Per-byte result list: a prefix (held bytes or a lone ESC) plus one tail ----
  logic [2:0] need;
  logic       cont;
  logic [1:0] pre_n;
  logic       pre_esc;
  logic       tail_v;
  res_t       tail_res;
  res_t       pre_res [3];

  assign need = seq_len(held_q[0]);
  assign cont = (b[7:6] == 2'b10);

  always_comb begin
    mode_d      = mode_q;
    held_cnt_d  = held_cnt_q;
    held_wr     = 1'b0;
    held_wr_idx = 2'd0;
    pre_n       = 2'd0;
    pre_esc     = 1'b0;
    tail_v      = 1'b0;
    tail_res    = fi_res;

    unique case (mode_q)
      ModeIdle: begin
        tail_v     = fi_v;
        mode_d     = fi_mode;
        held_wr    = fi_hold;
        held_cnt_d = fi_hold ? 2'd1 : 2'd0;
      end
      ModeUtf: begin
        if (!cont || (held_cnt_q == 2'd0) || (need == 3'd0)) begin
          // broken sequence: flush held bytes, restart on this byte
          pre_n      = held_cnt_q;
          tail_v     = fi_v;
          mode_d     = fi_mode;
          held_wr    = fi_hold;
          held_cnt_d = fi_hold ? 2'd1 : 2'd0;
        end else if (({1'b0, held_cnt_q} + 3'd1) == need) begin
          tail_v = 1'b1;
          priority case (need)
            3'd2: tail_res.cp = {10'd0, held_q[0][4:0], b[5:0]};
            3'd3: tail_res.cp = {5'd0, held_q[0][3:0], held_q[1][5:0], b[5:0]};
            default: tail_res.cp = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0],
                                    b[5:0]};
          endcase
          tail_res.kind = KindUtf8;
          mode_d        = ModeIdle;
          held_cnt_d    = 2'd0;
        end else begin
          if (held_cnt_q < 2'd3) begin
            held_wr     = 1'b1;
            held_wr_idx = held_cnt_q;
            held_cnt_d  = held_cnt_q + 2'd1;
          end
          if (chunk_end) begin
            // cut off at chunk end: everything held, this byte included, as Latin-1
            pre_n         = held_cnt_q;
            tail_v        = (held_cnt_q < 2'd3);
            tail_res.kind = KindLatin1;
            mode_d        = ModeIdle;
            held_cnt_d    = 2'd0;
          end
        end
      end
      ModeEsc: begin
        if (b == ByteBracket) begin
          if (chunk_end) begin
            tail_v   = 1'b1;
            tail_res = '{cp: '0, kind: KindCtrl};
            mode_d   = ModeIdle;
          end else begin
            mode_d = ModeCsi;
          end
        end else begin
          // lone ESC, then this byte from idle
          pre_n      = 2'd1;
          pre_esc    = 1'b1;
          tail_v     = fi_v;
          mode_d     = fi_mode;
          held_wr    = fi_hold;
          held_cnt_d = fi_hold ? 2'd1 : 2'd0;
        end
      end
      ModeCsi: begin
        if (((b >= ByteLowA) && (b <= ByteLowZ)) || chunk_end) begin
          tail_v   = 1'b1;
          tail_res = '{cp: '0, kind: KindCtrl};
          mode_d   = ModeIdle;
        end
      end
      default: begin
        mode_d = ModeIdle;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pre_res[i] = pre_esc ? '{cp: {13'd0, ByteEsc}, kind: KindAscii}
                           : '{cp: {13'd0, held_q[i]}, kind: KindLatin1};
    end
    for (int i = 0; i < MaxResults; i++) begin
      bnd_d[i] = ((i < 3) && (3'(i) < {1'b0, pre_n})) ? pre_res[(i < 3) ? i : 0] : tail_res;
    end
    bnd_cnt = {1'b0, pre_n} + {2'd0, tail_v};
  end

  // ---- Control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeIdle;
      held_cnt_q <= 2'd0;
      rem_q      <= 3'd0;
      idx_q      <= 2'd0;
    end else begin
      if (in_acc) begin
        mode_q     <= mode_d;
        held_cnt_q <= held_cnt_d;
        rem_q      <= bnd_cnt;
        idx_q      <= 2'd0;
      end else if (out_acc) begin
        rem_q <= rem_q - 3'd1;
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // ---- Payload registers ----
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bnd_q <= bnd_d;
      if (held_wr) begin
        held_q[held_wr_idx] <= b;
      end
    end
  end

  // ---- Assertions ----
  a_stall_multi : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q > 3'd1) |-> !in_i.ready)
    else $error("input taken while more than one result is pending");

  a_utf_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeUtf) |-> (held_cnt_q != 2'd0))
    else $error("inside a UTF-8 sequence with no held lead byte");

  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != ModeUtf) |-> (held_cnt_q == 2'd0))
    else $error("held bytes outside a UTF-8 sequence");

  a_drain_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.payload.run_last && !in_acc) |=> !out_o.valid)
    else $error("result beat shown after the last one of its byte");

endmodule

@@ bench/utf8_terminal_input_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 terminal input decoder testbench
// Drives terminal bytes through the decoder with random idling on both
// channels, predicts every codepoint in a scoreboard and checks each result
// beat against the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_terminal_input_decoder_tb;
  import utd_pkg::*;

  localparam int unsigned ClkHalf   = 10;
  localparam int unsigned ResetLen  = 10;
  localparam int unsigned LongHold  = 300;   // receiver hold-off that backs up the block
  localparam int unsigned IdleLimit = 2000;  // cycles with no beat on either side
  localparam int unsigned TailWait  = 16;
  localparam int unsigned MaxShown  = 10;

  // Decoder state as the scoreboard tracks it
  typedef enum logic [1:0] {
    ModeIdle,
    ModeUtf,
    ModeEsc,
    ModeCsi
  } dec_mode_e;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the result beats of each accepted byte and checks
  // the beats that come out, in order.
  // --------------------------------------------------------------------------
  class codepoint_scoreboard;
    logic [7:0]  held [3];
    int unsigned held_n;
    dec_mode_e   mode;
    res_t        step_codes[$];     // results of the byte being predicted
    out_beat_t   expected_codes[$]; // predicted beats not yet seen
    int unsigned fail_count;

    function void note_fail(string msg);
      if (fail_count < MaxShown) begin
        $display("%0t: %s", $time, msg);
      end
      fail_count++;
    endfunction

    function int unsigned lead_len(logic [7:0] b);
      if (b[7:5] == 3'b110) return 2;
      if (b[7:4] == 4'b1110) return 3;
      if (b[7:3] == 5'b11110) return 4;
      return 0;
    endfunction

    function void add(logic [20:0] cp, logic [1:0] kind);
      res_t r;
      r.cp   = cp;
      r.kind = kind;
      step_codes.push_back(r);
    endfunction

    // held bytes of a dead sequence go out one by one as Latin-1
    function void flush_held();
      for (int i = 0; i < held_n; i++) begin
        add({13'd0, held[i]}, KindLatin1);
      end
      held_n = 0;
      mode   = ModeIdle;
    endfunction

    function void from_idle(logic [7:0] b, logic ce);
      mode   = ModeIdle;
      held_n = 0;
      if (b == ByteEsc) begin
        if (ce) add({13'd0, ByteEsc}, KindAscii);
        else mode = ModeEsc;
      end else if (!b[7]) begin
        add({13'd0, b}, KindAscii);
      end else if (lead_len(b) == 0 || ce) begin
        add({13'd0, b}, KindLatin1);
      end else begin
        held[0] = b;
        held_n  = 1;
        mode    = ModeUtf;
      end
    endfunction

    function void in_sequence(logic [7:0] b, logic ce);
      int unsigned need;
      logic [20:0] cp;
      need = lead_len(held[0]);
      // not a continuation: drop the sequence and restart on this byte
      if (b[7:6] != 2'b10 || held_n == 0 || need == 0) begin
        flush_held();
        from_idle(b, ce);
        return;
      end
      if (held_n + 1 == need) begin
        case (need)
          2:       cp = {10'd0, held[0][4:0], b[5:0]};
          3:       cp = {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
          default: cp = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
        endcase
        add(cp, KindUtf8);
        held_n = 0;
        mode   = ModeIdle;
        return;
      end
      if (held_n < 3) begin
        held[held_n] = b;
        held_n++;
      end
      // chunk ended mid-sequence
      if (ce) flush_held();
    endfunction

    function void note_byte(in_beat_t beat);
      out_beat_t e;
      logic [7:0] b;
      logic ce;
      b  = beat.in_byte;
      ce = beat.chunk_end;
      step_codes.delete();
      case (mode)
        ModeUtf: in_sequence(b, ce);
        ModeEsc: begin
          if (b == ByteBracket) begin
            if (ce) begin
              add('0, KindCtrl);
              mode = ModeIdle;
            end else begin
              mode = ModeCsi;
            end
          end else begin
            add({13'd0, ByteEsc}, KindAscii);
            from_idle(b, ce);
          end
        end
        ModeCsi: begin
          if ((b >= ByteLowA && b <= ByteLowZ) || ce) begin
            add('0, KindCtrl);
            mode = ModeIdle;
          end
        end
        default: from_idle(b, ce);
      endcase
      foreach (step_codes[i]) begin
        e.code_point = step_codes[i].cp;
        e.code_kind  = step_codes[i].kind;
        e.run_last   = (i == step_codes.size() - 1);
        expected_codes.push_back(e);
      end
    endfunction

    function void check_code(out_beat_t got);
      out_beat_t e;
      if (expected_codes.size() == 0) begin
        note_fail($sformatf("unexpected beat: cp %h kind %0d last %0d",
                            got.code_point, got.code_kind, got.run_last));
        return;
      end
      e = expected_codes.pop_front();
      if (got.code_point !== e.code_point || got.code_kind !== e.code_kind ||
          got.run_last !== e.run_last) begin
        note_fail($sformatf("mismatch: exp cp %h kind %0d last %0d, got cp %h kind %0d last %0d",
                            e.code_point, e.code_kind, e.run_last,
                            got.code_point, got.code_kind, got.run_last));
      end
    endfunction

    function int unsigned pending_count();
      return expected_codes.size();
    endfunction

    function void close_out();
      if (expected_codes.size() != 0) begin
        note_fail($sformatf("%0d predicted beats never came out", expected_codes.size()));
        fail_count += expected_codes.size() - 1;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  utd_stream_if #(.payload_t(in_beat_t))  in_if ();
  utd_stream_if #(.payload_t(out_beat_t)) out_if ();

  utf8_terminal_input_decoder u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(ClkHalf) clk = ~clk;

  codepoint_scoreboard sb;

  bit          in_quiet  = 1'b0;  // sender offers back to back
  bit          out_quiet = 1'b0;  // receiver never stalls
  bit          hold_req  = 1'b0;  // ask the receiver for one long hold-off
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // About one byte in twelve closes a read chunk
  function automatic logic rand_ce();
    return ($urandom_range(0, 99) < 8);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor and watchdog. Inputs are noted before outputs are checked so a
  // same-edge pass-through would still find its prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_byte(in_if.payload);
      if (out_if.valid && out_if.ready) sb.check_code(out_if.payload);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready pattern, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int unsigned n;
    out_if.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
        n = out_quiet ? 0 : pick_gap();
        if (n > 0) begin
          out_if.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // One input beat; valid stays up into the next call when there is no gap.
  task automatic send(input logic [7:0] b, input logic ce);
    int unsigned n;
    in_beat_t beat;
    n = in_quiet ? 0 : pick_gap();
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    beat.in_byte   = b;
    beat.chunk_end = ce;
    in_if.valid   <= 1'b1;
    in_if.payload <= beat;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sender pauses until every predicted beat is out
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] lead_byte(input int unsigned len);
    case (len)
      2:       return 8'hc0 | 8'($urandom_range(0, 31));
      3:       return 8'he0 | 8'($urandom_range(0, 15));
      default: return 8'hf0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  // One random sequence: mostly well formed, some broken, some noise
  task automatic send_sequence();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      send(8'($urandom_range(0, 127)), rand_ce());
    end else if (r < 55) begin
      len = $urandom_range(2, 4);
      send(lead_byte(len), rand_ce());
      repeat (len - 1) send(cont_byte(), rand_ce());
    end else if (r < 70) begin
      // control sequence: parameter bytes, then a lowercase final
      send(ByteEsc, rand_ce());
      send(ByteBracket, rand_ce());
      repeat ($urandom_range(0, 3)) send(8'($urandom_range(8'h30, 8'h3f)), rand_ce());
      send(8'($urandom_range(ByteLowA, ByteLowZ)), rand_ce());
    end else if (r < 78) begin
      send(ByteEsc, rand_ce());
      send(8'($urandom_range(0, 255)), rand_ce());
    end else if (r < 88) begin
      // sequence broken by an arbitrary byte
      len = $urandom_range(2, 4);
      send(lead_byte(len), rand_ce());
      repeat ($urandom_range(0, len - 2)) send(cont_byte(), rand_ce());
      send(8'($urandom_range(0, 255)), rand_ce());
    end else begin
      send(8'($urandom_range(0, 255)), rand_ce());
    end
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_sequence();
  endtask

  initial begin
    sb = new();
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    repeat (ResetLen) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes and the decoder's corner cases
    send(8'h00, 1'b0);
    send(8'h7f, 1'b1);
    send(8'hc3, 1'b0);                  // two-byte sequence
    send(8'ha9, 1'b0);
    send(8'he2, 1'b0);                  // three-byte sequence
    send(8'h82, 1'b0);
    send(8'hac, 1'b0);
    send(8'hf7, 1'b0);                  // four-byte, largest codepoint
    send(8'hbf, 1'b0);
    send(8'hbf, 1'b0);
    send(8'hbf, 1'b0);
    send(8'h80, 1'b0);                  // stray continuation as lead
    send(8'hc3, 1'b1);                  // lead byte at chunk end
    send(8'he2, 1'b0);                  // chunk ends mid-sequence
    send(8'h82, 1'b1);
    send(8'hf0, 1'b0);                  // three held bytes flushed, then ASCII
    send(8'h90, 1'b0);
    send(8'h80, 1'b0);
    send(8'h41, 1'b0);
    send(ByteEsc, 1'b1);                // ESC at chunk end
    send(ByteEsc, 1'b0);                // ESC not followed by '['
    send(8'hff, 1'b0);
    send(ByteEsc, 1'b0);                // chunk ends right on '['
    send(ByteBracket, 1'b1);
    send(ByteEsc, 1'b0);                // control sequence closed by a letter
    send(ByteBracket, 1'b0);
    send(ByteLowZ, 1'b0);
    send(ByteEsc, 1'b0);                // chunk ends inside control sequence
    send(ByteBracket, 1'b0);
    send(8'h31, 1'b1);
    drain();

    // Random with idling on both sides
    send_random(90);
    drain();

    // Receiver holds off while the sender keeps offering
    hold_req  = 1'b1;
    in_quiet  = 1'b1;
    send_random(40);
    in_quiet  = 1'b0;
    drain();

    // Full rate both ways
    in_quiet  = 1'b1;
    out_quiet = 1'b1;
    send_random(60);
    in_quiet  = 1'b0;
    out_quiet = 1'b0;

    send_random(40);

    in_if.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (TailWait) @(posedge clk);
    sb.close_out();
    if (sb.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
